/* rtl/core/iot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_pkg
// shared types and constants of the image orientation transform
// ----------------------------------------------------------------------------
package iot_pkg;

  localparam int PixW     = 16;
  localparam int ModeW    = 3;
  localparam int SizeW    = 9;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] REG_MODE   = 2'd0;
  localparam logic [RegIdxW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_HEIGHT = 2'd2;

  localparam logic [ModeW-1:0] MODE_IDENT  = 3'd0;
  localparam logic [ModeW-1:0] MODE_VFLIP  = 3'd1;
  localparam logic [ModeW-1:0] MODE_HFLIP  = 3'd2;
  localparam logic [ModeW-1:0] MODE_ROT90  = 3'd3;
  localparam logic [ModeW-1:0] MODE_ROT180 = 3'd4;
  localparam logic [ModeW-1:0] MODE_ROT270 = 3'd5;

  localparam logic [SizeW-1:0] SIZE_RESET = 9'd256;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic             mode_wr;
    logic             size_wr;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } rd_t;

endpackage

/* rtl/core/iot_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_in_if
// input channel: load or fetch transaction
// ----------------------------------------------------------------------------
interface iot_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] pixel_in;

  modport source (output valid, output func, output pixel_in, input ready);
  modport sink (input valid, input func, input pixel_in, output ready);
endinterface

/* rtl/core/iot_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_out_if
// output channel: transformed pixel transaction
// ----------------------------------------------------------------------------
interface iot_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* rtl/core/iot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module iot_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/iot_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_regs
// apb configuration registers: mode, frame width, frame height
// ----------------------------------------------------------------------------
module iot_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iot_pkg::CfgAddrW-1:0]   paddr,
  input  logic [iot_pkg::CfgDataW-1:0]   pwdata,
  output logic [iot_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output iot_pkg::cfg_t                  cfg_o
);
  import iot_pkg::*;

  logic [ModeW-1:0]   mode_q, mode_d;
  logic [SizeW-1:0]   width_q, width_d;
  logic [SizeW-1:0]   height_q, height_d;
  logic [RegIdxW-1:0] idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = paddr[CfgAddrW-1:2];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    mode_d        = mode_q;
    width_d       = width_q;
    height_d      = height_q;
    cfg_o.mode_wr = 1'b0;
    cfg_o.size_wr = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_MODE: begin
          mode_d        = pwdata[ModeW-1:0];
          cfg_o.mode_wr = 1'b1;
        end
        REG_WIDTH: begin
          width_d       = pwdata[SizeW-1:0];
          cfg_o.size_wr = 1'b1;
        end
        REG_HEIGHT: begin
          height_d      = pwdata[SizeW-1:0];
          cfg_o.size_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDENT;
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = CfgDataW'(mode_q);
      REG_WIDTH:  prdata = CfgDataW'(width_q);
      REG_HEIGHT: prdata = CfgDataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

/* rtl/core/iot_addr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_addr
// load and emit counters, source coordinate mapping and frame store access
// ----------------------------------------------------------------------------
module iot_addr #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  iot_pkg::cfg_t                                cfg_i,
  input  logic                                         valid_i,
  input  logic                                         ready_i,
  input  logic                                         func_i,
  input  logic [iot_pkg::PixW-1:0]                     pixel_i,
  output logic                                         we_o,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      waddr_o,
  output logic [iot_pkg::PixW-1:0]                     wdata_o,
  output logic                                         re_o,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      raddr_o,
  output iot_pkg::rd_t                                 rd_o
);
  import iot_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int IW  = $clog2(MAX_WIDTH);
  localparam int IH  = $clog2(MAX_HEIGHT);
  localparam int CW  = (IW > IH) ? IW : IH;
  localparam int SWW = $clog2(MAX_WIDTH + 1);
  localparam int SWH = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = (SWW > SWH) ? SWW : SWH;

  logic [SWW-1:0] w;
  logic [SWH-1:0] h;
  logic [SW-1:0]  ow, oh;
  logic           swapped;

  logic [IW-1:0]  lo_q, lo_d;
  logic [IH-1:0]  li_q, li_d;
  logic [CW-1:0]  eo_q, eo_d;
  logic [CW-1:0]  ei_q, ei_d;
  logic           ready_q, ready_d;

  logic           acc, load, fetch;
  logic           l_inner_end, l_outer_end;
  logic           e_inner_end, e_outer_end;
  logic [IW-1:0]  si;
  logic [IH-1:0]  sj;
  logic [IW-1:0]  si_flip;
  logic [IH-1:0]  sj_flip;
  logic [IW-1:0]  si_r90;
  logic [IH-1:0]  sj_r90;
  logic [IW-1:0]  si_r270;
  logic [IH-1:0]  sj_r270;

  // size clamp: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cfg_i.width == '0) begin
      w = SWW'(1);
    end else if (32'(cfg_i.width) > 32'(MAX_WIDTH)) begin
      w = SWW'(MAX_WIDTH);
    end else begin
      w = SWW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h = SWH'(1);
    end else if (32'(cfg_i.height) > 32'(MAX_HEIGHT)) begin
      h = SWH'(MAX_HEIGHT);
    end else begin
      h = SWH'(cfg_i.height);
    end
  end

  assign swapped = (cfg_i.mode == MODE_ROT90) || (cfg_i.mode == MODE_ROT270);
  assign ow      = swapped ? SW'(h) : SW'(w);
  assign oh      = swapped ? SW'(w) : SW'(h);

  assign acc   = valid_i && ready_i;
  assign load  = acc && !func_i;
  assign fetch = acc && func_i && ready_q;

  assign l_inner_end = (32'(li_q) + 32'd1) >= 32'(h);
  assign l_outer_end = (32'(lo_q) + 32'd1) >= 32'(w);
  assign e_inner_end = (32'(ei_q) + 32'd1) >= 32'(oh);
  assign e_outer_end = (32'(eo_q) + 32'd1) >= 32'(ow);

  // mirrored and rotated coordinates
  assign si_flip = IW'(32'(w) - 32'd1 - 32'(eo_q));
  assign sj_flip = IH'(32'(h) - 32'd1 - 32'(ei_q));
  assign si_r90  = IW'(ei_q);
  assign sj_r90  = IH'(32'(h) - 32'd1 - 32'(eo_q));
  assign si_r270 = IW'(32'(w) - 32'd1 - 32'(ei_q));
  assign sj_r270 = IH'(eo_q);

  always_comb begin
    unique case (cfg_i.mode)
      MODE_VFLIP: begin
        si = IW'(eo_q);
        sj = sj_flip;
      end
      MODE_HFLIP: begin
        si = si_flip;
        sj = IH'(ei_q);
      end
      MODE_ROT90: begin
        si = si_r90;
        sj = sj_r90;
      end
      MODE_ROT180: begin
        si = si_flip;
        sj = sj_flip;
      end
      MODE_ROT270: begin
        si = si_r270;
        sj = sj_r270;
      end
      default: begin
        si = IW'(eo_q);
        sj = IH'(ei_q);
      end
    endcase
  end

  assign we_o    = load;
  assign waddr_o = AW'(32'(lo_q) * 32'(MAX_HEIGHT) + 32'(li_q));
  assign wdata_o = pixel_i;
  assign re_o    = fetch;
  assign raddr_o = AW'(32'(si) * 32'(MAX_HEIGHT) + 32'(sj));

  assign rd_o.valid = fetch;
  assign rd_o.last  = e_inner_end && e_outer_end;

  always_comb begin
    lo_d    = lo_q;
    li_d    = li_q;
    eo_d    = eo_q;
    ei_d    = ei_q;
    ready_d = ready_q;
    if (cfg_i.size_wr) begin
      lo_d    = '0;
      li_d    = '0;
      eo_d    = '0;
      ei_d    = '0;
      ready_d = 1'b0;
    end else if (cfg_i.mode_wr) begin
      eo_d = '0;
      ei_d = '0;
    end else if (load) begin
      if (l_inner_end) begin
        li_d = '0;
        if (l_outer_end) begin
          lo_d    = '0;
          ready_d = 1'b1;
        end else begin
          lo_d = lo_q + IW'(1);
        end
      end else begin
        li_d = li_q + IH'(1);
      end
    end else if (fetch) begin
      if (e_inner_end) begin
        ei_d = '0;
        eo_d = e_outer_end ? '0 : eo_q + CW'(1);
      end else begin
        ei_d = ei_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      li_q    <= '0;
      eo_q    <= '0;
      ei_q    <= '0;
      ready_q <= 1'b0;
    end else begin
      lo_q    <= lo_d;
      li_q    <= li_d;
      eo_q    <= eo_d;
      ei_q    <= ei_d;
      ready_q <= ready_d;
    end
  end

endmodule

/* rtl/core/iot_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iot_out
// pending read tracking and output register with stall control
// ----------------------------------------------------------------------------
module iot_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  iot_pkg::rd_t             rd_i,
  input  logic [iot_pkg::PixW-1:0] rdata_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [iot_pkg::PixW-1:0] pixel_o,
  output logic                     last_o,
  output logic                     in_ready_o
);
  import iot_pkg::*;

  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;
  logic            oval_q, oval_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic            last_q, last_d;
  logic            take;

  assign take       = pend_q && (!oval_q || out_ready_i);
  assign in_ready_o = !pend_q || !oval_q || out_ready_i;

  always_comb begin
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    oval_d      = oval_q;
    pix_d       = pix_q;
    last_d      = last_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (take) begin
      oval_d = 1'b1;
      pix_d  = rdata_i;
      last_d = pend_last_q;
      pend_d = 1'b0;
    end
    if (rd_i.valid) begin
      pend_d      = 1'b1;
      pend_last_d = rd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    pix_q       <= pix_d;
    last_q      <= last_d;
  end

  assign out_valid_o = oval_q;
  assign pixel_o     = pix_q;
  assign last_o      = last_q;

endmodule

/* rtl/core/image_orientation_transform_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_orientation_transform_top
// frame store with flip and 90/180/270 rotation on readout
// ----------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  in_i      in    valid / ready     func, pixel_in
//  out_o     out   valid / ready     pixel_out, frame_last
//  apb       in    psel / penable    paddr, pwdata, prdata
//
//  one transaction per cycle unless in_i stalls; a load writes the frame store
//  in its accept cycle; a fetch reads the frame store, and its result passes
//  through the registered ram read and then the output register
//  reset clears counters, frame ready flag and config registers; store is not cleared
//  a stalled output holds one result in the ram read register, then in_i stalls
// ----------------------------------------------------------------------------
module image_orientation_transform_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  iot_in_if.sink                        in_i,
  iot_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iot_pkg::CfgAddrW-1:0]  paddr,
  input  logic [iot_pkg::CfgDataW-1:0]  pwdata,
  output logic [iot_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import iot_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);

  cfg_t            cfg;
  rd_t             rd;
  logic            we, re, in_ready;
  logic [AW-1:0]   waddr, raddr;
  logic [PixW-1:0] wdata, rdata;

  iot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iot_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_i.valid),
    .ready_i (in_ready),
    .func_i  (in_i.func),
    .pixel_i (in_i.pixel_in),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rd_o    (rd)
  );

  iot_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  iot_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd),
    .rdata_i     (rdata),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .pixel_o     (out_o.pixel_out),
    .last_o      (out_o.frame_last),
    .in_ready_o  (in_ready)
  );

  assign in_i.ready = in_ready;

endmodule

/* tb/tb_image_orientation_transform_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_orientation_transform_top
// self-checking bench: loads random frames over the input channel, reads them
// back in every orientation and compares each pixel and end-of-frame flag
// against a shadow frame store, with random idles and output stalls
// ----------------------------------------------------------------------------
module tb_image_orientation_transform_top;
  import iot_pkg::*;

  localparam int MAX_W        = 256;
  localparam int MAX_H        = 256;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [ModeW-1:0]   MODE_SPARE = 3'd7;
  localparam logic [RegIdxW-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel;
  } pix_cmd_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } pix_due_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  logic            drv_valid  = 1'b0;
  logic            drv_func   = 1'b0;
  logic [PixW-1:0] drv_pixel  = '0;
  logic            take_ready = 1'b0;
  logic            in_fire    = 1'b0;

  iot_in_if  in_if ();
  iot_out_if out_if ();

  assign in_if.valid    = drv_valid;
  assign in_if.func     = drv_func;
  assign in_if.pixel_in = drv_pixel;
  assign out_if.ready   = take_ready;

  image_orientation_transform_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pix_cmd_t feed_q[$];
  pix_due_t px_due_q[$];

  bit calm        = 1'b0;
  int gap_left    = 0;
  int stall_left  = 0;
  int items_sent  = 0;
  int fail_count  = 0;
  int quiet_count = 0;

  // shadow copy of the block state
  logic [PixW-1:0]  shadow_frame [MAX_W*MAX_H];
  logic [ModeW-1:0] orient     = MODE_IDENT;
  logic [SizeW-1:0] cols_reg   = SIZE_RESET;
  logic [SizeW-1:0] rows_reg   = SIZE_RESET;
  int               fill_col   = 0;
  int               fill_row   = 0;
  int               scan_major = 0;
  int               scan_minor = 0;
  bit               frame_full = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int clamp_dim(logic [SizeW-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void write_shadow_reg(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    case (idx)
      REG_MODE: begin
        orient     = value[ModeW-1:0];
        scan_major = 0;
        scan_minor = 0;
      end
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) cols_reg = value[SizeW-1:0];
        else rows_reg = value[SizeW-1:0];
        fill_col   = 0;
        fill_row   = 0;
        scan_major = 0;
        scan_minor = 0;
        frame_full = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void orient_predict(pix_cmd_t cmd);
    int w, h, ow, oh, a, b, si, sj;
    bit swapped;
    pix_due_t due;
    w = clamp_dim(cols_reg, MAX_W);
    h = clamp_dim(rows_reg, MAX_H);
    if (cmd.func == FUNC_LOAD) begin
      if (fill_col < w && fill_row < h) shadow_frame[fill_col*MAX_H + fill_row] = cmd.pixel;
      if (fill_row + 1 >= h) begin
        fill_row = 0;
        if (fill_col + 1 >= w) begin
          fill_col   = 0;
          frame_full = 1'b1;
        end else begin
          fill_col = fill_col + 1;
        end
      end else begin
        fill_row = fill_row + 1;
      end
      return;
    end
    // fetch before a complete frame is dropped
    if (!frame_full) return;
    swapped = (orient == MODE_ROT90) || (orient == MODE_ROT270);
    ow = swapped ? h : w;
    oh = swapped ? w : h;
    a  = (scan_major >= ow) ? ow - 1 : scan_major;
    b  = (scan_minor >= oh) ? oh - 1 : scan_minor;
    case (orient)
      MODE_VFLIP: begin
        si = a;
        sj = h - 1 - b;
      end
      MODE_HFLIP: begin
        si = w - 1 - a;
        sj = b;
      end
      MODE_ROT90: begin
        si = b;
        sj = h - 1 - a;
      end
      MODE_ROT180: begin
        si = w - 1 - a;
        sj = h - 1 - b;
      end
      MODE_ROT270: begin
        si = w - 1 - b;
        sj = a;
      end
      default: begin
        si = a;
        sj = b;
      end
    endcase
    due.pixel = shadow_frame[si*MAX_H + sj];
    due.last  = (a + 1 >= ow) && (b + 1 >= oh);
    if (b + 1 >= oh) begin
      scan_minor = 0;
      scan_major = (a + 1 >= ow) ? 0 : a + 1;
    end else begin
      scan_minor = b + 1;
      scan_major = a;
    end
    px_due_q.push_back(due);
  endfunction

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        drv_valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        drv_valid <= 1'b1;
        drv_func  <= feed_q[0].func;
        drv_pixel <= feed_q[0].pixel;
        void'(feed_q.pop_front());
        gap_left  <= pick_pause();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // output ready with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      take_ready <= 1'b0;
    end else begin
      take_ready <= 1'b1;
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_pause() : 0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    pix_due_t due;
    in_fire <= rst_ni && drv_valid && in_if.ready;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready)
        write_shadow_reg(paddr[CfgAddrW-1:2], pwdata);
      if (drv_valid && in_if.ready)
        orient_predict('{func: drv_func, pixel: drv_pixel});
      if (out_if.valid && take_ready) begin
        if (px_due_q.size() == 0) begin
          $display("%0t ns: transaction with nothing due, pixel_out=%h frame_last=%b",
                   $time, out_if.pixel_out, out_if.frame_last);
          fail_count++;
        end else begin
          due = px_due_q.pop_front();
          if (out_if.pixel_out !== due.pixel) begin
            $display("%0t ns: pixel_out expected %h actual %h",
                     $time, due.pixel, out_if.pixel_out);
            fail_count++;
          end
          if (out_if.frame_last !== due.last) begin
            $display("%0t ns: frame_last expected %b actual %b",
                     $time, due.last, out_if.frame_last);
            fail_count++;
          end
        end
      end
    end
    if ((drv_valid && in_if.ready) || (out_if.valid && take_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= QUIET_LIMIT) begin
      $display("image_orientation_transform_top test failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic void queue_item(logic func, logic [PixW-1:0] pixel);
    feed_q.push_back('{func: func, pixel: pixel});
    items_sent++;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (feed_q.size() != 0 || drv_valid || px_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_frame_phase(logic [SizeW-1:0] cols, logic [SizeW-1:0] rows, bit big);
    int area;
    bit noisy;
    area  = clamp_dim(cols, MAX_W) * clamp_dim(rows, MAX_H);
    noisy = !big && ($urandom_range(0, 3) == 0);
    calm  = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_WIDTH, CfgDataW'(cols));
      cfg_write(REG_HEIGHT, CfgDataW'(rows));
    end else begin
      cfg_write(REG_HEIGHT, CfgDataW'(rows));
      cfg_write(REG_WIDTH, CfgDataW'(cols));
    end
    cfg_write(REG_MODE, CfgDataW'($urandom_range(0, 7)));
    // stray fetches and partial loads before the frame is complete
    if (noisy)
      repeat ($urandom_range(1, 5)) queue_item(1'($urandom_range(0, 1)), PixW'($urandom));
    repeat (area) queue_item(FUNC_LOAD, PixW'($urandom));
    repeat (big ? 8 : area + $urandom_range(0, 2 * area))
      queue_item(FUNC_FETCH, PixW'($urandom));
    wait_idle();
    // mode change restarts readout of the same frame
    cfg_write(REG_MODE, CfgDataW'($urandom_range(0, 7)));
    repeat (big ? 8 : $urandom_range(1, 2 * area)) queue_item(FUNC_FETCH, PixW'($urandom));
    // reload while reading: old and new pixels mix
    if (noisy)
      repeat ($urandom_range(area, 3 * area))
        queue_item(1'($urandom_range(0, 1)), PixW'($urandom));
    wait_idle();
  endtask

  initial begin
    int phase;
    logic [SizeW-1:0] cols;
    logic [SizeW-1:0] rows;
    phase = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing loaded yet: fetches are dropped, a load writes one pixel and advances the counters
    queue_item(FUNC_FETCH, '1);
    queue_item(FUNC_LOAD, '1);
    queue_item(FUNC_FETCH, '0);
    wait_idle();

    // zero sizes act as one pixel, unused mode code reads as identity
    cfg_write(REG_WIDTH, '0);
    cfg_write(REG_HEIGHT, '0);
    cfg_write(REG_MODE, CfgDataW'(MODE_SPARE));
    cfg_write(REG_SPARE, '1);
    queue_item(FUNC_FETCH, '1);
    queue_item(FUNC_LOAD, 16'hFFFF);
    queue_item(FUNC_FETCH, '0);
    queue_item(FUNC_LOAD, 16'h0000);
    queue_item(FUNC_FETCH, '0);
    queue_item(FUNC_FETCH, '1);
    wait_idle();

    // small frame rotated one way, then the other after a mode change
    cfg_write(REG_WIDTH, 2);
    cfg_write(REG_HEIGHT, 3);
    cfg_write(REG_MODE, CfgDataW'(MODE_ROT90));
    queue_item(FUNC_LOAD, 16'h0000);
    queue_item(FUNC_LOAD, 16'hFFFF);
    queue_item(FUNC_LOAD, 16'h8000);
    queue_item(FUNC_LOAD, 16'h0001);
    queue_item(FUNC_LOAD, 16'h5A5A);
    queue_item(FUNC_LOAD, 16'hA5A5);
    repeat (6) queue_item(FUNC_FETCH, 16'h5555);
    wait_idle();
    cfg_write(REG_MODE, CfgDataW'(MODE_ROT270));
    repeat (4) queue_item(FUNC_FETCH, 16'hAAAA);
    wait_idle();

    while (items_sent < RANDOM_ITEMS || phase < 5) begin
      if (phase == 1) begin
        run_frame_phase(9'd511, 9'd1, 1'b1);
      end else if (phase == 4) begin
        run_frame_phase(9'd1, 9'd256, 1'b1);
      end else begin
        cols = ($urandom_range(0, 9) == 0) ? '0 : SizeW'($urandom_range(1, 6));
        rows = ($urandom_range(0, 9) == 0) ? '0 : SizeW'($urandom_range(1, 6));
        run_frame_phase(cols, rows, 1'b0);
      end
      phase++;
    end

    if (fail_count == 0) begin
      $display("image_orientation_transform_top test passed");
    end else begin
      $display("image_orientation_transform_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/iot_pkg.sv
rtl/core/iot_in_if.sv
rtl/core/iot_out_if.sv
rtl/core/iot_ram.sv
rtl/core/iot_regs.sv
rtl/core/iot_addr.sv
rtl/core/iot_out.sv
rtl/core/image_orientation_transform_top.sv
tb/tb_image_orientation_transform_top.sv
